// ===== sv/emrd_pkg.sv =====
// Shared types, widths and codes for the edge mixed-radix delta codec.
`default_nettype none

package emrd_pkg;

  // Field and register widths
  localparam int unsigned LocW      = 5;   // location_count register, effective L
  localparam int unsigned FieldLocW = 4;   // from/to fields
  localparam int unsigned StateW    = 16;  // state_count register, start/end fields
  localparam int unsigned CodeW     = 40;  // code and delta ports
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  // Datapath widths
  localparam int unsigned MacXW = 26;               // widest multiplicand operand
  localparam int unsigned ProdW = MacXW + StateW;   // product / code / maxv
  localparam int unsigned SumW  = ProdW + 1;        // previous code plus delta
  localparam int unsigned SqW   = 2 * StateW;       // S*S
  localparam int unsigned QuoW  = StateW;           // widest quotient

  // Quotient bit counts per division phase
  localparam int unsigned LocQuoBits   = 5;
  localparam int unsigned StateQuoBits = StateW;

  // Parameter defaults
  localparam int unsigned MaxLocationsDef = 16;
  localparam int unsigned MaxStatesDef    = 65535;

  // Request type codes
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LOC_COUNT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_STATE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ORDER = 2'd2
  } status_e;

  // Multiply-add request: p = x * m + y
  typedef struct packed {
    logic              en;
    logic [MacXW-1:0]  x;
    logic [StateW-1:0] m;
    logic [StateW-1:0] y;
  } mac_req_t;

  // Add/subtract request: res = a + b, or a - b when sub is set
  typedef struct packed {
    logic            sub;
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
  } alu_req_t;

  // carry set on subtract means a >= b
  typedef struct packed {
    logic            carry;
    logic [SumW-1:0] res;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/emrd_mac.sv =====
// Shared multiply-add unit with registered product.
`default_nettype none

module emrd_mac (
  input  wire                             clk_i,
  input  wire emrd_pkg::mac_req_t         req_i,
  output logic [emrd_pkg::ProdW-1:0]      p_o
);

  logic [emrd_pkg::ProdW-1:0] prod;
  logic [emrd_pkg::ProdW-1:0] p_q;

  assign prod = req_i.x * req_i.m;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= prod + emrd_pkg::ProdW'(req_i.y);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/emrd_alu.sv =====
// Shared add/subtract unit with carry out.
`default_nettype none

module emrd_alu (
  input  wire emrd_pkg::alu_req_t   req_i,
  output emrd_pkg::alu_rsp_t        rsp_o
);

  logic [emrd_pkg::SumW:0]   full;
  logic [emrd_pkg::SumW-1:0] b_op;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign full = {1'b0, req_i.a} + {1'b0, b_op} + (emrd_pkg::SumW + 1)'(req_i.sub);

  assign rsp_o.res   = full[emrd_pkg::SumW-1:0];
  assign rsp_o.carry = full[emrd_pkg::SumW];

endmodule

`default_nettype wire

// ===== sv/edge_mixed_radix_delta_codec_core.sv =====
// Top level of the edge mixed-radix delta codec: sequencer, state and output stage.
//
//  Channel | Signals                                    | Handshake
//  --------+--------------------------------------------+--------------------------
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i            | write when cfg_we_i high
//  request | req_type_i .. delta_in_i                   | in_valid_i / in_ready_o
//  result  | code_o .. status_o                         | out_valid_o / out_ready_i
//
// Encode: accept, three multiply-add steps, order check, hand-off; an edge
//   with a field out of range goes from accept straight to hand-off.
// Decode: accept, six multiply-add steps that also form the sum, range check,
//   26 divider steps for the 5+5+16 quotient bits, produced one per cycle on
//   the shared add/subtract unit, then hand-off. A sum at or past the end of
//   the index space skips the divider.
// Reset clears the previous code, the sequencer and the output valid, and
//   loads location_count = 16, state_count = 1.
// A finished result waits in the output register; the block takes the next
//   transaction while it waits and stalls only at hand-off if it is still held.
`default_nettype none

module edge_mixed_radix_delta_codec_core #(
  parameter int unsigned MAX_LOCATIONS = emrd_pkg::MaxLocationsDef,
  parameter int unsigned MAX_STATES    = emrd_pkg::MaxStatesDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration
  input  wire                                 cfg_we_i,
  input  wire  [emrd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [emrd_pkg::CfgDataW-1:0]       cfg_data_i,
  // request
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 req_type_i,
  input  wire                                 list_start_i,
  input  wire  [emrd_pkg::FieldLocW-1:0]      from_loc_i,
  input  wire  [emrd_pkg::FieldLocW-1:0]      to_loc_i,
  input  wire  [emrd_pkg::StateW-1:0]         start_state_i,
  input  wire  [emrd_pkg::StateW-1:0]         end_state_i,
  input  wire  [emrd_pkg::CodeW-1:0]          delta_in_i,
  // result
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [emrd_pkg::CodeW-1:0]          code_o,
  output logic [emrd_pkg::CodeW-1:0]          delta_out_o,
  output logic [emrd_pkg::FieldLocW-1:0]      from_out_o,
  output logic [emrd_pkg::FieldLocW-1:0]      to_out_o,
  output logic [emrd_pkg::StateW-1:0]         start_out_o,
  output logic [emrd_pkg::StateW-1:0]         end_out_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned LocW   = emrd_pkg::LocW;
  localparam int unsigned StateW = emrd_pkg::StateW;
  localparam int unsigned FldW   = emrd_pkg::FieldLocW;
  localparam int unsigned CodeW  = emrd_pkg::CodeW;
  localparam int unsigned ProdW  = emrd_pkg::ProdW;
  localparam int unsigned SumW   = emrd_pkg::SumW;
  localparam int unsigned SqW    = emrd_pkg::SqW;
  localparam int unsigned QuoW   = emrd_pkg::QuoW;
  localparam int unsigned MacXW  = emrd_pkg::MacXW;

  // Clamp limits, capped by what the register can hold
  localparam int unsigned LocRegMax = (1 << LocW) - 1;
  localparam logic [LocW-1:0] LocLimit =
    LocW'((MAX_LOCATIONS > LocRegMax) ? LocRegMax : MAX_LOCATIONS);
  localparam logic [StateW-1:0] StateLimit = StateW'(MAX_STATES);

  localparam logic [2:0] EncLastStep = 3'd2;
  localparam logic [2:0] DecLastStep = 3'd5;
  localparam logic [3:0] LocCntInit   = 4'(emrd_pkg::LocQuoBits - 1);
  localparam logic [3:0] StateCntInit = 4'(emrd_pkg::StateQuoBits - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    PH_FROM  = 2'd0,
    PH_TO    = 2'd1,
    PH_START = 2'd2
  } phase_e;

  // configuration registers
  logic [LocW-1:0]   loc_cnt_q;
  logic [StateW-1:0] state_cnt_q;
  logic [LocW-1:0]   eff_loc;
  logic [StateW-1:0] eff_st;

  // sequencer
  state_e     state_q;
  phase_e     phase_q;
  logic [2:0] step_q;
  logic [3:0] cnt_q;

  // captured request
  logic              op_q;
  logic [FldW-1:0]   a_q, b_q;
  logic [StateW-1:0] c_q, d_q;
  logic [CodeW-1:0]  delta_q;

  // arithmetic state
  logic [ProdW-1:0] prev_q;
  logic [SumW-1:0]  sum_q;
  logic [ProdW-1:0] lss_q, maxv_q, rem_q, dsh_q;
  logic [SqW-1:0]   ss_q;
  logic [QuoW-1:0]  quo_q;
  logic [QuoW-1:0]  quo_d;
  logic [ProdW-1:0] rem_d;

  // finished result waiting for the output register
  logic [CodeW-1:0]  res_code_q, res_delta_q;
  logic [FldW-1:0]   res_from_q, res_to_q;
  logic [StateW-1:0] res_start_q, res_end_q;
  emrd_pkg::status_e res_status_q;

  // output register
  logic              out_valid_q;
  logic [CodeW-1:0]  out_code_q, out_delta_q;
  logic [FldW-1:0]   out_from_q, out_to_q;
  logic [StateW-1:0] out_start_q, out_end_q;
  emrd_pkg::status_e out_status_q;

  logic in_accept;
  logic range_fail;
  logic out_free;
  logic last_step;

  emrd_pkg::mac_req_t mac_req;
  logic [ProdW-1:0]   mac_p;
  emrd_pkg::alu_req_t alu_req;
  emrd_pkg::alu_rsp_t alu_rsp;

  // Effective radices: zero counts as one, large values saturate
  always_comb begin
    eff_loc = loc_cnt_q;
    if (eff_loc == '0) begin
      eff_loc = LocW'(1);
    end else if (eff_loc > LocLimit) begin
      eff_loc = LocLimit;
    end
    eff_st = state_cnt_q;
    if (eff_st == '0) begin
      eff_st = StateW'(1);
    end else if (eff_st > StateLimit) begin
      eff_st = StateLimit;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_step  = (op_q == emrd_pkg::REQ_DECODE) ? (step_q == DecLastStep)
                                                     : (step_q == EncLastStep);

  assign range_fail = (LocW'(from_loc_i) >= eff_loc) || (LocW'(to_loc_i) >= eff_loc) ||
                      (start_state_i >= eff_st) || (end_state_i >= eff_st);

  // Multiply-add schedule.
  // Encode: a*L+b, (.)*S+c, (.)*S+d.
  // Decode: L*S, (L*S)*S = L*S*S, L*L, (L*L)*S, (L*L*S)*S = max, S*S.
  always_comb begin
    mac_req = '0;
    if (state_q == ST_MAC) begin
      mac_req.en = 1'b1;
      if (op_q == emrd_pkg::REQ_ENCODE) begin
        case (step_q)
          3'd0: begin
            mac_req.x = MacXW'(a_q);
            mac_req.m = StateW'(eff_loc);
            mac_req.y = StateW'(b_q);
          end
          3'd1: begin
            mac_req.x = MacXW'(mac_p);
            mac_req.m = eff_st;
            mac_req.y = c_q;
          end
          default: begin
            mac_req.x = MacXW'(mac_p);
            mac_req.m = eff_st;
            mac_req.y = d_q;
          end
        endcase
      end else begin
        case (step_q)
          3'd0: begin
            mac_req.x = MacXW'(eff_loc);
            mac_req.m = eff_st;
          end
          3'd2: begin
            mac_req.x = MacXW'(eff_loc);
            mac_req.m = StateW'(eff_loc);
          end
          3'd5: begin
            mac_req.x = MacXW'(eff_st);
            mac_req.m = eff_st;
          end
          default: begin
            mac_req.x = MacXW'(mac_p);
            mac_req.m = eff_st;
          end
        endcase
      end
    end
  end

  // Add/subtract unit use: decode sum, order/range checks, divider steps
  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_MAC: begin
        alu_req.a = SumW'(prev_q);
        alu_req.b = SumW'(delta_q);
      end
      ST_CHK: begin
        alu_req.sub = 1'b1;
        if (op_q == emrd_pkg::REQ_ENCODE) begin
          alu_req.a = SumW'(mac_p);
          alu_req.b = SumW'(prev_q);
        end else begin
          alu_req.a = sum_q;
          alu_req.b = SumW'(maxv_q);
        end
      end
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = SumW'(rem_q);
        alu_req.b   = SumW'(dsh_q);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Restoring division step
  assign quo_d = {quo_q[QuoW-2:0], alu_rsp.carry};
  assign rem_d = alu_rsp.carry ? ProdW'(alu_rsp.res) : rem_q;

  emrd_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .p_o   (mac_p)
  );

  emrd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Control state, configuration and previous code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_cnt_q   <= LocW'(16);
      state_cnt_q <= StateW'(1);
      state_q     <= ST_IDLE;
      phase_q     <= PH_FROM;
      step_q      <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          emrd_pkg::CFG_LOC_COUNT:   loc_cnt_q   <= cfg_data_i[LocW-1:0];
          emrd_pkg::CFG_STATE_COUNT: state_cnt_q <= cfg_data_i[StateW-1:0];
          default: ;
        endcase
      end

      // hand-off loads a new result; otherwise a taken result empties the register
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (list_start_i) begin
              prev_q <= '0;
            end
            step_q <= '0;
            if (req_type_i == emrd_pkg::REQ_ENCODE && range_fail) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          step_q <= step_q + 3'd1;
          if (last_step) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (op_q == emrd_pkg::REQ_ENCODE) begin
            if (alu_rsp.carry) begin
              prev_q <= mac_p;
            end
            state_q <= ST_DONE;
          end else if (alu_rsp.carry) begin
            // sum at or beyond L*L*S*S
            state_q <= ST_DONE;
          end else begin
            phase_q <= PH_FROM;
            cnt_q   <= LocCntInit;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            case (phase_q)
              PH_FROM: begin
                phase_q <= PH_TO;
                cnt_q   <= LocCntInit;
              end
              PH_TO: begin
                phase_q <= PH_START;
                cnt_q   <= StateCntInit;
              end
              PH_START: begin
                prev_q  <= ProdW'(sum_q);
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_q    <= req_type_i;
          a_q     <= from_loc_i;
          b_q     <= to_loc_i;
          c_q     <= start_state_i;
          d_q     <= end_state_i;
          delta_q <= delta_in_i;
          // out-of-range edge: all result fields zero
          res_code_q   <= '0;
          res_delta_q  <= '0;
          res_from_q   <= '0;
          res_to_q     <= '0;
          res_start_q  <= '0;
          res_end_q    <= '0;
          res_status_q <= emrd_pkg::STATUS_RANGE;
        end
      end
      ST_MAC: begin
        if (op_q == emrd_pkg::REQ_DECODE) begin
          if (step_q == 3'd0) begin
            sum_q <= alu_rsp.res;
          end
          if (step_q == 3'd2) begin
            lss_q <= mac_p;
          end
          if (step_q == DecLastStep) begin
            maxv_q <= mac_p;
          end
        end
      end
      ST_CHK: begin
        ss_q <= SqW'(mac_p);
        if (op_q == emrd_pkg::REQ_ENCODE) begin
          res_code_q  <= mac_p[CodeW-1:0];
          res_from_q  <= a_q;
          res_to_q    <= b_q;
          res_start_q <= c_q;
          res_end_q   <= d_q;
          if (alu_rsp.carry) begin
            res_delta_q  <= alu_rsp.res[CodeW-1:0];
            res_status_q <= emrd_pkg::STATUS_OK;
          end else begin
            res_delta_q  <= '0;
            res_status_q <= emrd_pkg::STATUS_ORDER;
          end
        end else begin
          res_code_q   <= sum_q[CodeW-1:0];
          res_delta_q  <= '0;
          res_from_q   <= '0;
          res_to_q     <= '0;
          res_start_q  <= '0;
          res_end_q    <= '0;
          res_status_q <= alu_rsp.carry ? emrd_pkg::STATUS_ORDER : emrd_pkg::STATUS_OK;
          rem_q <= ProdW'(sum_q);
          dsh_q <= lss_q << LocCntInit;
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= rem_d;
        if (cnt_q == '0) begin
          quo_q <= '0;
          case (phase_q)
            PH_FROM: begin
              res_from_q <= quo_d[FldW-1:0];
              dsh_q      <= ProdW'(ss_q) << LocCntInit;
            end
            PH_TO: begin
              res_to_q <= quo_d[FldW-1:0];
              dsh_q    <= ProdW'(eff_st) << StateCntInit;
            end
            PH_START: begin
              res_start_q <= quo_d[StateW-1:0];
              res_end_q   <= rem_d[StateW-1:0];
            end
            default: ;
          endcase
        end else begin
          dsh_q <= dsh_q >> 1;
          quo_q <= quo_d;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_code_q   <= res_code_q;
          out_delta_q  <= res_delta_q;
          out_from_q   <= res_from_q;
          out_to_q     <= res_to_q;
          out_start_q  <= res_start_q;
          out_end_q    <= res_end_q;
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = out_code_q;
  assign delta_out_o = out_delta_q;
  assign from_out_o  = out_from_q;
  assign to_out_o    = out_to_q;
  assign start_out_o = out_start_q;
  assign end_out_o   = out_end_q;
  assign status_o    = out_status_q;

  // Previous code moves only on a list start, a good encode or a finished decode
  a_prev_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_accept && state_q != ST_CHK && state_q != ST_DIV) |=> $stable(prev_q))
    else $error("previous code changed outside an update point");

  // Restoring divider invariant: remainder below twice the shifted divisor
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (SumW'(rem_q) < {dsh_q, 1'b0}))
    else $error("divider remainder out of bound");

  // Busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready after accept");

  // Hand-off publishes the result and frees the sequencer
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_o && in_ready_o))
    else $error("result hand-off failed");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for edge_mixed_radix_delta_codec_core: random and directed edge lists vs. a predictor.
`timescale 1ns / 1ps

module tb_top;

  // Package widths used here
  localparam int unsigned LocW            = emrd_pkg::LocW;
  localparam int unsigned FieldLocW       = emrd_pkg::FieldLocW;
  localparam int unsigned StateW          = emrd_pkg::StateW;
  localparam int unsigned CodeW           = emrd_pkg::CodeW;
  localparam int unsigned CfgIdxW         = emrd_pkg::CfgIdxW;
  localparam int unsigned CfgDataW        = emrd_pkg::CfgDataW;
  localparam int unsigned MaxLocationsDef = emrd_pkg::MaxLocationsDef;
  localparam int unsigned MaxStatesDef    = emrd_pkg::MaxStatesDef;

  // Run limits
  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned SettleCycles = 50;
  localparam int unsigned NumPhases = 9;
  localparam int unsigned ItemsPerPhase = 155;

  // One request transaction and one result transaction, as the ports carry them
  typedef struct packed {
    logic                 req_type;
    logic                 list_start;
    logic [FieldLocW-1:0] from_loc;
    logic [FieldLocW-1:0] to_loc;
    logic [StateW-1:0]    start_state;
    logic [StateW-1:0]    end_state;
    logic [CodeW-1:0]     delta_in;
  } edge_req_t;

  typedef struct packed {
    logic [CodeW-1:0]     code;
    logic [CodeW-1:0]     delta;
    logic [FieldLocW-1:0] from_loc;
    logic [FieldLocW-1:0] to_loc;
    logic [StateW-1:0]    start_state;
    logic [StateW-1:0]    end_state;
    emrd_pkg::status_e    status;
  } edge_result_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT-facing signals, all known from time zero
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = emrd_pkg::CFG_LOC_COUNT;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  edge_req_t           cur_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CodeW-1:0]     code_o, delta_out_o;
  logic [FieldLocW-1:0] from_out_o, to_out_o;
  logic [StateW-1:0]    start_out_o, end_out_o;
  logic [1:0]           status_o;

  edge_mixed_radix_delta_codec_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (cur_req.req_type),
    .list_start_i (cur_req.list_start),
    .from_loc_i   (cur_req.from_loc),
    .to_loc_i     (cur_req.to_loc),
    .start_state_i(cur_req.start_state),
    .end_state_i  (cur_req.end_state),
    .delta_in_i   (cur_req.delta_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .code_o       (code_o),
    .delta_out_o  (delta_out_o),
    .from_out_o   (from_out_o),
    .to_out_o     (to_out_o),
    .start_out_o  (start_out_o),
    .end_out_o    (end_out_o),
    .status_o     (status_o)
  );

  // Stimulus queue, expectations and bookkeeping
  edge_req_t    pending_edges[$];
  edge_result_t expected_results[$];
  int unsigned  edges_sent = 0;
  int unsigned  edges_taken = 0;
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;   // chance the sender holds valid low on a free cycle
  int unsigned  recv_stall_pct = 0;  // chance the receiver drops ready in a cycle
  logic         req_taken = 1'b0;    // a request transaction completed at the last rising edge

  // Predictor state: shadow registers and the running code of the current list
  logic [LocW-1:0]   loc_cfg = 5'd16;
  logic [StateW-1:0] state_cfg = 16'd1;
  logic [63:0]       prev_code = '0;

  // Radices as the block uses them: zero counts as one, large values saturate
  function automatic logic [63:0] eff_loc(logic [LocW-1:0] v);
    if (v == 0) return 64'd1;
    if (v > MaxLocationsDef) return 64'(MaxLocationsDef);
    return 64'(v);
  endfunction

  function automatic logic [63:0] eff_state(logic [StateW-1:0] v);
    if (v == 0) return 64'd1;
    if (v > MaxStatesDef) return 64'(MaxStatesDef);
    return 64'(v);
  endfunction

  // Works out the result of one request and advances the running code.
  // All arithmetic is carried at 64 bits so the decode sum keeps its carry.
  function automatic edge_result_t predict_edge(edge_req_t r);
    logic [63:0] l, s, maxv, code, sum, rem, ss, lss;
    edge_result_t res;
    l = eff_loc(loc_cfg);
    s = eff_state(state_cfg);
    maxv = l * l * s * s;
    res = '0;
    res.status = emrd_pkg::STATUS_OK;
    // list start clears even when the transaction itself fails
    if (r.list_start) prev_code = '0;
    if (r.req_type == emrd_pkg::REQ_ENCODE) begin
      if (r.from_loc >= l || r.to_loc >= l || r.start_state >= s || r.end_state >= s) begin
        res.status = emrd_pkg::STATUS_RANGE;
      end else begin
        code = ((r.from_loc * l + r.to_loc) * s + r.start_state) * s + r.end_state;
        res.code = code[CodeW-1:0];
        res.from_loc = r.from_loc;
        res.to_loc = r.to_loc;
        res.start_state = r.start_state;
        res.end_state = r.end_state;
        if (code < prev_code) begin
          res.status = emrd_pkg::STATUS_ORDER;
        end else begin
          res.delta = CodeW'(code - prev_code);
          prev_code = code;
        end
      end
    end else begin
      sum = prev_code + 64'(r.delta_in);
      res.code = sum[CodeW-1:0];
      if (sum >= maxv) begin
        res.status = emrd_pkg::STATUS_ORDER;
      end else begin
        ss = s * s;
        lss = l * ss;
        rem = sum;
        res.from_loc = FieldLocW'(rem / lss);
        rem = rem % lss;
        res.to_loc = FieldLocW'(rem / ss);
        rem = rem % ss;
        res.start_state = StateW'(rem / s);
        res.end_state = StateW'(rem % s);
        prev_code = sum;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Driver: new request on a falling edge once the previous one is taken.
  // Valid holds with a steady payload until the transaction completes.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || req_taken) begin
        if (pending_edges.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req <= pending_edges.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: shadows register writes, predicts at request acceptance and
  // compares each result transaction with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    edge_result_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      loc_cfg = 5'd16;
      state_cfg = 16'd1;
      prev_code = '0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (cfg_we) begin
        case (cfg_idx)
          emrd_pkg::CFG_LOC_COUNT: begin
            loc_cfg = cfg_data[LocW-1:0];
          end
          emrd_pkg::CFG_STATE_COUNT: begin
            state_cfg = cfg_data[StateW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_edge(cur_req));
        edges_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: code 0x%0h", code_o);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("code", 64'(want.code), 64'(code_o));
          check_field("delta_out", 64'(want.delta), 64'(delta_out_o));
          check_field("from_out", 64'(want.from_loc), 64'(from_out_o));
          check_field("to_out", 64'(want.to_loc), 64'(to_out_o));
          check_field("start_out", 64'(want.start_state), 64'(start_out_o));
          check_field("end_out", 64'(want.end_state), 64'(end_out_o));
          check_field("status", 64'(want.status), 64'(status_o));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // Generator view of the configuration, used to shape well-formed lists
  logic [63:0] gen_l = 64'd16;
  logic [63:0] gen_s = 64'd1;
  logic [63:0] gen_max = 64'd256;
  logic [63:0] gen_prev = '0;

  function automatic logic [63:0] rand_upto(logic [63:0] hi);
    logic [63:0] lim, r;
    lim = hi >> $urandom_range(0, 40);  // spread steps over many scales
    r = {$urandom, $urandom};
    return r % (lim + 1);
  endfunction

  task automatic push_item(edge_req_t r);
    pending_edges.insert(pending_edges.size(), r);
    edges_sent++;
  endtask

  task automatic push_enc(logic ls, logic [FieldLocW-1:0] f, logic [FieldLocW-1:0] t,
                          logic [StateW-1:0] st, logic [StateW-1:0] en);
    edge_req_t r;
    r = '0;
    r.req_type = emrd_pkg::REQ_ENCODE;
    r.list_start = ls;
    r.from_loc = f;
    r.to_loc = t;
    r.start_state = st;
    r.end_state = en;
    r.delta_in = CodeW'({$urandom, $urandom});  // ignored on encode
    push_item(r);
  endtask

  task automatic push_dec(logic ls, logic [CodeW-1:0] delta);
    edge_req_t r;
    r = '0;
    r.req_type = emrd_pkg::REQ_DECODE;
    r.list_start = ls;
    r.from_loc = FieldLocW'($urandom);  // ignored on decode
    r.to_loc = FieldLocW'($urandom);
    r.start_state = StateW'($urandom);
    r.end_state = StateW'($urandom);
    r.delta_in = delta;
    push_item(r);
  endtask

  // Splits a code into edge fields under the current radices
  task automatic push_enc_code(logic ls, logic [63:0] code);
    logic [63:0] c, en, st, t;
    c = code;
    en = c % gen_s;
    c = c / gen_s;
    st = c % gen_s;
    c = c / gen_s;
    t = c % gen_l;
    c = c / gen_l;
    push_enc(ls, FieldLocW'(c), FieldLocW'(t), StateW'(st), StateW'(en));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == emrd_pkg::CFG_LOC_COUNT) gen_l = eff_loc(data[LocW-1:0]);
    else gen_s = eff_state(data);
    gen_max = gen_l * gen_l * gen_s * gen_s;
  endtask

  // Holds off until every request is taken and every result has come back
  task automatic wait_drained();
    while (edges_taken != edges_sent || expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Mostly sorted edge lists (encode-heavy or decode-heavy) with random
  // content and a few broken entries; the rest are raw random transactions.
  task automatic gen_lists(int unsigned n_items);
    int unsigned made, len, j, enc_pct;
    logic ls;
    logic [63:0] room, val;
    logic [FieldLocW-1:0] f;
    logic [StateW-1:0] st, en;
    edge_req_t r;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        r = '0;
        r.req_type = 1'($urandom);
        r.list_start = 1'($urandom);
        r.from_loc = FieldLocW'($urandom);
        r.to_loc = FieldLocW'($urandom);
        r.start_state = StateW'($urandom);
        r.end_state = StateW'($urandom);
        r.delta_in = CodeW'({$urandom, $urandom});
        push_item(r);
        made++;
      end else begin
        len = $urandom_range(1, 12);
        enc_pct = ($urandom_range(0, 1) == 0) ? 90 : 10;
        for (j = 0; j < len; j++) begin
          // a few lists carry on from whatever came before
          ls = (j == 0) && ($urandom_range(0, 9) != 0);
          if (ls) gen_prev = '0;
          room = (gen_prev < gen_max) ? gen_max - 1 - gen_prev : '0;
          if ($urandom_range(0, 99) < enc_pct) begin
            if ($urandom_range(0, 15) == 0 && gen_prev > 0) begin
              // edge sorted below its predecessor
              push_enc_code(ls, rand_upto(gen_prev - 1));
            end else if ($urandom_range(0, 15) == 0) begin
              // one field at or beyond its radix
              f = FieldLocW'($urandom_range(0, 15));
              st = StateW'($urandom);
              en = StateW'($urandom);
              if (gen_s < MaxStatesDef && $urandom_range(0, 1) == 0)
                st = StateW'($urandom_range(32'(gen_s), 65535));
              else if (gen_l < MaxLocationsDef)
                f = FieldLocW'($urandom_range(32'(gen_l), 15));
              else
                en = 16'hFFFF;
              push_enc(ls, f, FieldLocW'($urandom), st, en);
            end else begin
              val = gen_prev + rand_upto(room);
              push_enc_code(ls, val);
              gen_prev = val;
            end
          end else begin
            if ($urandom_range(0, 15) == 0) begin
              // sum lands at or past the end of the index space
              push_dec(ls, CodeW'(room + 1 + rand_upto(gen_max)));
            end else begin
              val = rand_upto(room);
              push_dec(ls, CodeW'(val));
              gen_prev = gen_prev + val;
            end
          end
          made++;
        end
      end
    end
  endtask

  // Main sequence: reset, directed cases, then configuration phases
  initial begin
    logic [CfgDataW-1:0] loc_wr[NumPhases];
    logic [CfgDataW-1:0] state_wr[NumPhases];
    logic [63:0] top_code;
    int unsigned p;

    // phase 0 runs on reset values; the rest cover both extremes of each
    // register, zero, and location values with the unused upper bits set
    loc_wr = '{16'd16, 16'd16, 16'hFFE1, 16'd0, 16'd31, 16'd5, 16'd16, 16'd3, 16'd12};
    state_wr = '{16'd1, 16'd65535, 16'd1, 16'd0, 16'd300, 16'd7, 16'd2, 16'd65535, 16'd1000};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset radices L=16 S=1 (index space 0..255)
    push_enc(1'b1, 4'd0, 4'd0, 16'd0, 16'd0);
    push_enc(1'b0, 4'd15, 4'd15, 16'd0, 16'd0);     // top code
    push_enc(1'b0, 4'd3, 4'd4, 16'd0, 16'd0);       // out of order
    push_enc(1'b0, 4'd15, 4'd15, 16'd0, 16'd0);     // equal code, zero delta
    push_enc(1'b0, 4'd0, 4'd0, 16'd1, 16'd0);       // start state out of range
    push_enc(1'b0, 4'd0, 4'd0, 16'd0, 16'hFFFF);    // end state out of range
    push_dec(1'b1, '0);
    push_dec(1'b0, 40'd255);
    push_dec(1'b0, 40'd1);                          // sum beyond the index space
    push_dec(1'b0, 40'hFF_FFFF_FFFF);               // sum carries past 40 bits
    push_enc(1'b1, 4'd0, 4'd0, 16'd0, 16'd5);       // failing item still clears the list
    push_dec(1'b0, 40'd5);

    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      if (p > 0) begin
        write_reg(emrd_pkg::CFG_LOC_COUNT, loc_wr[p]);
        write_reg(emrd_pkg::CFG_STATE_COUNT, state_wr[p]);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (p == 1) begin
        // Directed at the widest radices L=16 S=65535
        top_code = gen_max - 1;
        push_enc(1'b1, 4'd15, 4'd15, 16'd65534, 16'd65534);
        push_enc(1'b0, 4'd0, 4'd0, 16'd0, 16'd0);
        push_dec(1'b1, CodeW'(top_code));
        push_dec(1'b0, 40'd1);
        push_enc(1'b0, 4'd15, 4'd15, 16'd65534, 16'd65534);
        push_dec(1'b0, '0);
      end
      gen_prev = '0;
      gen_lists(ItemsPerPhase / 2);
      // sender holds off here until the block has returned everything
      wait_drained();
      gen_lists(ItemsPerPhase - ItemsPerPhase / 2);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/emrd_pkg.sv
sv/emrd_mac.sv
sv/emrd_alu.sv
sv/edge_mixed_radix_delta_codec_core.sv
test/tb_top.sv
